>>> hdl/addressed_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ADDRESSED_FRAME_RECEIVER_DEFINES_SVH
`define ADDRESSED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AFR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/afr_pkg.sv
// Types, codes and constants of the addressed frame receiver.
// No dependencies; imported by every module of the block.
package afr_pkg;

   localparam int unsigned HEADER_LEN    = 10;
   localparam int unsigned CSR_INDEX_W   = 3;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam int unsigned ADDR_W        = 32;
   localparam int unsigned COUNT_W       = 4;
   localparam int unsigned REMAIN_W      = 9;
   localparam int unsigned DIGIT_W       = 6;
   localparam int unsigned ALIAS_IDX_W   = 2;
   localparam int unsigned ALIAS_CNT_W   = 3;
   localparam int unsigned IDLE_W        = 4;

   localparam logic [ADDR_W-1:0]  BROADCAST_ADDR = 32'h2B2B_2B2B;   // "++++"
   localparam logic [IDLE_W-1:0]  IDLE_LIMIT_RST = 4'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALIAS_COUNT = 3'd0,
      CSR_ALIAS_A     = 3'd1,
      CSR_ALIAS_B     = 3'd2,
      CSR_ALIAS_C     = 3'd3,
      CSR_ALIAS_D     = 3'd4,
      CSR_IDLE_LIMIT  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_END     = 2'd1,
      KIND_ABORT   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_NONE      = 2'd0,
      CLASS_BROADCAST = 2'd1,
      CLASS_ALIAS     = 2'd2
   } class_type;

   typedef enum logic {
      MODE_BYTE = 1'b0,
      MODE_IDLE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [7:0]          payload_byte;
      logic                last;
      class_type           match_class;
      logic [ALIAS_IDX_W-1:0] alias_hit;
      logic [ADDR_W-1:0]   source_address;
   } rsp_type;

   // Scalar settings handed from the register file to the frame engine.
   typedef struct packed {
      logic [ALIAS_CNT_W-1:0] alias_count;
      logic [IDLE_W-1:0]      idle_limit;
   } cfg_type;

   // Base64 digit value; anything outside the alphabet decodes as zero.
   function automatic logic [DIGIT_W-1:0] digit64(input logic [7:0] c);
      logic [DIGIT_W-1:0] d;
      d = '0;
      priority if (c >= "A" && c <= "Z") d = DIGIT_W'(c - "A");
      else if (c >= "a" && c <= "z")     d = DIGIT_W'(c - "a" + 8'd26);
      else if (c >= "0" && c <= "9")     d = DIGIT_W'(c - "0" + 8'd52);
      else if (c == "+")                 d = 6'd62;
      else if (c == "/")                 d = 6'd63;
      else                               d = '0;
      return d;
   endfunction

endpackage

>>> hdl/afr_csr.sv
// Configuration registers of the frame receiver: alias count, aliases, idle limit.
// Depends on afr_pkg.
module afr_csr import afr_pkg::*; #(
   parameter int unsigned ALIAS_SLOTS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [CSR_INDEX_W-1:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]              csr_data,
   output cfg_type                            cfg,
   output logic [ALIAS_SLOTS-1:0][ADDR_W-1:0] alias_regs
);

   logic                               wr_en;
   cfg_type                            cfg_ff;
   logic [ALIAS_SLOTS-1:0][ADDR_W-1:0] alias_ff;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alias_count <= '0;
         cfg_ff.idle_limit  <= IDLE_LIMIT_RST;
         alias_ff           <= '0;
      end else if (wr_en) begin
         if (csr_index == CSR_ALIAS_COUNT) begin
            cfg_ff.alias_count <= csr_data[ALIAS_CNT_W-1:0];
         end
         if (csr_index == CSR_IDLE_LIMIT) begin
            cfg_ff.idle_limit <= csr_data[IDLE_W-1:0];
         end
         // alias slot i sits at index CSR_ALIAS_A + i; indexes past the list drop
         for (int i = 0; i < ALIAS_SLOTS; i++) begin
            if (csr_index == CSR_INDEX_W'(CSR_ALIAS_A) + CSR_INDEX_W'(i)) begin
               alias_ff[i] <= csr_data[ADDR_W-1:0];
            end
         end
      end
   end

   assign cfg        = cfg_ff;
   assign alias_regs = alias_ff;

endmodule

>>> hdl/afr_core.sv
// Frame engine: header capture, length decode, address classification, payload tagging.
// Depends on afr_pkg and the assertion macros header.
`include "addressed_frame_receiver_defines.svh"
module afr_core import afr_pkg::*; #(
   parameter int unsigned ALIAS_SLOTS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  req_type                            item,
   input  cfg_type                            cfg,
   input  logic [ALIAS_SLOTS-1:0][ADDR_W-1:0] alias_regs,
   output logic                               has_result,
   output rsp_type                            result
);

   logic [COUNT_W-1:0]     header_count_ff, header_count_in, cur_hc;
   logic [ADDR_W-1:0]      dest_ff, dest_in, cur_dest;
   logic [ADDR_W-1:0]      src_ff, src_in, cur_src;
   logic [DIGIT_W-1:0]     len_hi_ff, len_hi_in, cur_len_hi;
   logic [REMAIN_W-1:0]    remain_ff, remain_in, cur_remain, remain_dec;
   logic [IDLE_W-1:0]      idle_left_ff, idle_left_in;
   class_type              class_ff, class_in, cur_class, hdr_class;
   logic [ALIAS_IDX_W-1:0] alias_ff, alias_in, cur_alias, hdr_alias;
   logic                   in_frame_ff, in_frame_in;
   logic [ALIAS_CNT_W-1:0] alias_limit;
   logic [DIGIT_W-1:0]     digit;
   logic [2*DIGIT_W-1:0]   length_bits;
   logic [REMAIN_W-1:0]    hdr_remain;
   logic                   alias_found;

   // Destination classification: broadcast first, then lowest matching alias.
   always_comb begin
      alias_limit = (cfg.alias_count > ALIAS_CNT_W'(ALIAS_SLOTS)) ?
                    ALIAS_CNT_W'(ALIAS_SLOTS) : cfg.alias_count;
      alias_found = 1'b0;
      hdr_alias   = '0;
      for (int i = ALIAS_SLOTS - 1; i >= 0; i--) begin
         if ((ALIAS_CNT_W'(i) < alias_limit) && (alias_regs[i] == cur_dest)) begin
            alias_found = 1'b1;
            hdr_alias   = ALIAS_IDX_W'(i);
         end
      end
      if (cur_dest == BROADCAST_ADDR) begin
         hdr_class = CLASS_BROADCAST;
         hdr_alias = '0;
      end else if (alias_found) begin
         hdr_class = CLASS_ALIAS;
      end else begin
         hdr_class = CLASS_NONE;
      end
   end

   assign digit       = digit64(item.rx_byte);
   assign length_bits = {cur_len_hi, digit};
   assign hdr_remain  = length_bits[2*DIGIT_W-1:3];     // bits / 8
   assign remain_dec  = cur_remain - REMAIN_W'(1);

   always_comb begin
      // a byte outside a frame opens a fresh one
      cur_hc     = header_count_ff;
      cur_dest   = dest_ff;
      cur_src    = src_ff;
      cur_len_hi = len_hi_ff;
      cur_remain = remain_ff;
      cur_class  = class_ff;
      cur_alias  = alias_ff;
      if (item.mode == MODE_BYTE && !in_frame_ff) begin
         cur_hc     = '0;
         cur_dest   = '0;
         cur_src    = '0;
         cur_len_hi = '0;
         cur_remain = '0;
         cur_class  = CLASS_NONE;
         cur_alias  = '0;
      end

      header_count_in = cur_hc;
      dest_in         = cur_dest;
      src_in          = cur_src;
      len_hi_in       = cur_len_hi;
      remain_in       = cur_remain;
      class_in        = cur_class;
      alias_in        = cur_alias;
      idle_left_in    = idle_left_ff;
      in_frame_in     = in_frame_ff;
      has_result      = 1'b0;
      result.kind         = KIND_PAYLOAD;
      result.payload_byte = '0;
      result.last         = 1'b0;

      if (item.mode == MODE_IDLE) begin
         if (in_frame_ff) begin
            if (idle_left_ff <= IDLE_W'(1)) begin
               has_result      = 1'b1;
               result.kind     = KIND_ABORT;
               result.last     = 1'b1;
               in_frame_in     = 1'b0;
               header_count_in = '0;
               remain_in       = '0;
               idle_left_in    = '0;
            end else begin
               idle_left_in = idle_left_ff - IDLE_W'(1);
            end
         end
      end else begin
         in_frame_in  = 1'b1;
         idle_left_in = cfg.idle_limit;
         if (cur_hc < COUNT_W'(HEADER_LEN)) begin
            header_count_in = cur_hc + COUNT_W'(1);
            if (cur_hc < COUNT_W'(4)) begin
               dest_in = {cur_dest[ADDR_W-9:0], item.rx_byte};
            end else if (cur_hc < COUNT_W'(8)) begin
               src_in = {cur_src[ADDR_W-9:0], item.rx_byte};
            end else if (cur_hc == COUNT_W'(8)) begin
               len_hi_in = digit;
            end else begin
               // last header byte: length known, destination classified
               remain_in       = hdr_remain;
               class_in        = hdr_class;
               alias_in        = hdr_alias;
               header_count_in = COUNT_W'(HEADER_LEN);
               if (hdr_remain == '0) begin
                  has_result      = 1'b1;
                  result.kind     = KIND_END;
                  result.last     = 1'b1;
                  in_frame_in     = 1'b0;
                  header_count_in = '0;
                  idle_left_in    = '0;
               end
            end
         end else begin
            has_result          = 1'b1;
            result.payload_byte = item.rx_byte;
            remain_in           = remain_dec;
            if (remain_dec == '0) begin
               result.last     = 1'b1;
               in_frame_in     = 1'b0;
               header_count_in = '0;
               idle_left_in    = '0;
            end
         end
      end

      result.match_class    = class_in;
      result.alias_hit      = (class_in == CLASS_ALIAS) ? alias_in : '0;
      result.source_address = src_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= '0;
         dest_ff         <= '0;
         src_ff          <= '0;
         len_hi_ff       <= '0;
         remain_ff       <= '0;
         idle_left_ff    <= '0;
         class_ff        <= CLASS_NONE;
         alias_ff        <= '0;
         in_frame_ff     <= 1'b0;
      end else if (fire) begin
         header_count_ff <= header_count_in;
         dest_ff         <= dest_in;
         src_ff          <= src_in;
         len_hi_ff       <= len_hi_in;
         remain_ff       <= remain_in;
         idle_left_ff    <= idle_left_in;
         class_ff        <= class_in;
         alias_ff        <= alias_in;
         in_frame_ff     <= in_frame_in;
      end
   end

   `AFR_ASSERT_IMP(a_idle_clean, clock, reset, !in_frame_ff, (header_count_ff == '0) && (remain_ff == '0), "closed frame left header or length state")
   `AFR_ASSERT_IMP(a_hc_range, clock, reset, 1'b1, header_count_ff <= COUNT_W'(HEADER_LEN), "header count past header length")
   `AFR_ASSERT_IMP(a_remain_hdr, clock, reset, remain_ff != '0, header_count_ff == COUNT_W'(HEADER_LEN), "payload count set before header done")

endmodule

>>> hdl/addressed_frame_receiver.sv
// Addressed frame receiver, top level.
// A beat passes through the input register, then the result register, before its result shows.
// Throughput: one beat per cycle while not stalled; the frame engine updates its state per beat.
// A result waiting in the output register does not block intake unless the next beat makes one.
// Reset (synchronous, active high) closes any frame, empties both registers, loads default CSRs.
// Depends on afr_pkg, afr_csr, afr_core and the assertion macros header.
`include "addressed_frame_receiver_defines.svh"
module addressed_frame_receiver import afr_pkg::*; #(
   parameter int unsigned ALIAS_SLOTS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // input stream
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // result stream
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type                            cfg;
   logic [ALIAS_SLOTS-1:0][ADDR_W-1:0] alias_regs;

   logic    req_valid_ff;
   req_type req_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic    has_result;
   rsp_type result;
   logic    out_free;
   logic    advance;

   afr_csr #(
      .ALIAS_SLOTS (ALIAS_SLOTS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .alias_regs (alias_regs)
   );

   afr_core #(
      .ALIAS_SLOTS (ALIAS_SLOTS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (req_data_ff),
      .cfg        (cfg),
      .alias_regs (alias_regs),
      .has_result (has_result),
      .result     (result)
   );

   // The result register frees up this cycle if empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // The held beat retires unless it makes a result and the result register is full.
   assign advance   = req_valid_ff && (!has_result || out_free);
   // Stall only while a held beat cannot retire; an empty input register always takes a beat.
   assign req_stall = req_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result is only written over a held one that is leaving this cycle.
   `AFR_ASSERT_IMP(a_no_overwrite, clock, reset,
      advance && has_result && rsp_valid_ff, !rsp_stall, "held result overwritten")
   // Stall only ever reflects a beat parked in the input register.
   `AFR_ASSERT_IMP(a_stall_src, clock, reset,
      req_stall, req_valid_ff && has_result, "input stalled without a pending result")
   // End and abort beats always close the frame.
   `AFR_ASSERT_IMP(a_close_last, clock, reset,
      rsp_valid_ff && (rsp_data_ff.kind != KIND_PAYLOAD),
      rsp_data_ff.last && (rsp_data_ff.payload_byte == '0), "end or abort beat without last")

endmodule

>>> tb/testbench.sv
// Self-checking bench for addressed_frame_receiver: header parsing, address classing,
// payload streaming, empty frames and idle timeouts, under random idling and a long hold-off.
// Depends on afr_pkg and the addressed_frame_receiver RTL.
module testbench import afr_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ALIAS_SLOTS  = 4;
   localparam int unsigned DEST_END     = 4;     // header bytes 0..3 carry the destination
   localparam int unsigned SRC_END      = 8;     // header bytes 4..7 carry the source
   localparam int          QUIET_LIMIT  = 2000;  // cycles without any beat before giving up
   localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int          SETTLE_CYCLES = 4;    // input reg + result reg, plus margin
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_0 = CSR_INDEX_W'(CSR_IDLE_LIMIT + 1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_1 = CSR_INDEX_W'(CSR_IDLE_LIMIT + 2);

   // DUT ports; every input is known from time zero.
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Register shadow, at reset values.
   logic [ALIAS_CNT_W-1:0] alias_count = '0;
   logic [ADDR_W-1:0]      alias_reg [4] = '{default: '0};
   logic [IDLE_W-1:0]      idle_limit = IDLE_LIMIT_RST;

   // Receiver state as the predictor tracks it.
   logic [COUNT_W-1:0]     hdr_count = '0;
   logic [ADDR_W-1:0]      dest      = '0;
   logic [ADDR_W-1:0]      src       = '0;
   logic [DIGIT_W-1:0]     len_hi    = '0;
   logic [REMAIN_W-1:0]    remaining = '0;
   logic [IDLE_W-1:0]      idle_left = '0;
   class_type              fr_class  = CLASS_NONE;
   logic [ALIAS_IDX_W-1:0] fr_alias  = '0;
   logic                   in_frame  = 1'b0;

   req_type beats_q [$];     // input beats waiting for the driver
   rsp_type expected_q [$];  // results the block still owes
   rsp_type want;

   int errors       = 0;
   int results_seen = 0;
   int byte_count   = 0;     // bytes queued in the current phase
   int send_gap_pct = 0;
   int stall_pct    = 0;
   int hold_req     = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int quiet        = 0;

   addressed_frame_receiver #(.ALIAS_SLOTS(ALIAS_SLOTS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Base64 digit value; characters outside the alphabet count as zero.
   function automatic logic [DIGIT_W-1:0] base64_value(logic [7:0] c);
      if (c >= "A" && c <= "Z") return DIGIT_W'(c - "A");
      if (c >= "a" && c <= "z") return DIGIT_W'(c - "a" + 26);
      if (c >= "0" && c <= "9") return DIGIT_W'(c - "0" + 52);
      if (c == "+") return DIGIT_W'(62);
      if (c == "/") return DIGIT_W'(63);
      return '0;
   endfunction

   // Result tagged with the frame's class and source as they stand right now.
   function automatic void queue_result(kind_type k, logic [7:0] b, logic l);
      rsp_type e;
      e.kind           = k;
      e.payload_byte   = b;
      e.last           = l;
      e.match_class    = fr_class;
      e.alias_hit      = (fr_class == CLASS_ALIAS) ? fr_alias : '0;
      e.source_address = src;
      expected_q.push_back(e);
   endfunction

   function automatic void close_frame();
      in_frame  = 1'b0;
      hdr_count = '0;
      remaining = '0;
      idle_left = '0;
   endfunction

   // Advance the receiver by one accepted input beat.
   function automatic void rx_predict(req_type r);
      logic [2*DIGIT_W-1:0] len_bits;
      int n;
      int i;
      if (r.mode == MODE_IDLE) begin
         if (!in_frame) return;             // idle between frames is ignored
         if (idle_left <= 1) begin          // timeout, also covers a zero limit
            queue_result(KIND_ABORT, 8'h00, 1'b1);
            close_frame();
         end else begin
            idle_left = idle_left - 1'b1;
         end
         return;
      end
      if (!in_frame) begin                  // any byte opens a new frame
         in_frame  = 1'b1;
         hdr_count = '0;
         dest      = '0;
         src       = '0;
         len_hi    = '0;
         remaining = '0;
         fr_class  = CLASS_NONE;
         fr_alias  = '0;
      end
      idle_left = idle_limit;
      if (hdr_count < HEADER_LEN) begin
         if (hdr_count < DEST_END) begin
            dest = {dest[ADDR_W-9:0], r.rx_byte};
         end else if (hdr_count < SRC_END) begin
            src = {src[ADDR_W-9:0], r.rx_byte};
         end else if (hdr_count == SRC_END) begin
            len_hi = base64_value(r.rx_byte);
         end else begin
            // Header complete: bits -> bytes, then class the destination.
            len_bits  = {len_hi, base64_value(r.rx_byte)};
            remaining = len_bits[2*DIGIT_W-1:3];
            hdr_count = COUNT_W'(HEADER_LEN);
            fr_class  = CLASS_NONE;
            fr_alias  = '0;
            n = (alias_count > ALIAS_SLOTS) ? int'(ALIAS_SLOTS) : int'(alias_count);
            if (dest == BROADCAST_ADDR) begin
               fr_class = CLASS_BROADCAST;    // broadcast wins over any alias
            end else begin
               for (i = 0; i < n; i++) begin
                  if (fr_class == CLASS_NONE && alias_reg[i] == dest) begin
                     fr_class = CLASS_ALIAS;
                     fr_alias = ALIAS_IDX_W'(i);
                  end
               end
            end
            if (remaining == 0) begin
               queue_result(KIND_END, 8'h00, 1'b1);
               close_frame();
            end
            return;
         end
         hdr_count = hdr_count + 1'b1;
         return;
      end
      remaining = remaining - 1'b1;
      queue_result(KIND_PAYLOAD, r.rx_byte, remaining == 0);
      if (remaining == 0) close_frame();
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------------------------

   function automatic void push_byte(logic [7:0] b);
      req_type r;
      r.mode    = MODE_BYTE;
      r.rx_byte = b;
      beats_q.push_back(r);
      byte_count++;
   endfunction

   // Idle tick; the byte lane carries junk that must be ignored.
   function automatic void push_idle();
      req_type r;
      r.mode    = MODE_IDLE;
      r.rx_byte = 8'($urandom());
      beats_q.push_back(r);
   endfunction

   function automatic void push_addr(logic [ADDR_W-1:0] a);
      int i;
      for (i = 3; i >= 0; i--) push_byte(a[8*i +: 8]);
   endfunction

   function automatic logic [7:0] b64_char(logic [DIGIT_W-1:0] v);
      if (v < 26) return "A" + 8'(v);
      if (v < 52) return "a" + 8'(v - 26);
      if (v < 62) return "0" + 8'(v - 52);
      if (v == 62) return "+";
      return "/";
   endfunction

   // A character outside the Base64 alphabet.
   function automatic logic [7:0] junk_char();
      case ($urandom_range(4))
         0:       return 8'($urandom_range(0, 42));
         1:       return 8'($urandom_range(44, 46));
         2:       return 8'($urandom_range(58, 64));
         3:       return 8'($urandom_range(91, 96));
         default: return 8'($urandom_range(123, 255));
      endcase
   endfunction

   // One frame with random content. Mostly well formed with short payloads and idle
   // gaps that stay under the timeout; now and then bad length digits, or a frame cut
   // short and either timed out or run straight into the next one. The longest frame
   // goes out without gaps.
   function automatic void gen_frame(bit big);
      logic [ADDR_W-1:0]  dest_w;
      logic [ADDR_W-1:0]  src_w;
      logic [DIGIT_W-1:0] hi_v;
      logic [DIGIT_W-1:0] lo_v;
      logic [7:0]         hi_c;
      logic [7:0]         lo_c;
      logic [7:0]         fb [$];
      int n_pay;
      int cut;
      int eff;
      int sel;
      int i;
      int k;
      eff = (idle_limit == 0) ? 1 : int'(idle_limit);
      case ($urandom_range(5))
         0:       dest_w = BROADCAST_ADDR;
         1:       dest_w = BROADCAST_ADDR ^ (32'h1 << $urandom_range(31));  // near miss
         2, 3:    dest_w = alias_reg[$urandom_range(3)];
         default: dest_w = $urandom();
      endcase
      src_w = $urandom();
      sel   = $urandom_range(99);
      if (big) begin
         hi_v = '1;
         lo_v = '1;
      end else begin
         hi_v = (sel < 80) ? DIGIT_W'(0) :
                (sel < 95) ? DIGIT_W'(1) : DIGIT_W'($urandom_range(2, 3));
         lo_v = DIGIT_W'($urandom());
      end
      hi_c = b64_char(hi_v);
      lo_c = b64_char(lo_v);
      if (!big && $urandom_range(9) == 0) begin
         hi_c = junk_char();
         hi_v = '0;
      end
      if (!big && $urandom_range(9) == 0) begin
         lo_c = junk_char();
         lo_v = '0;
      end
      n_pay = int'({hi_v, lo_v}) >> 3;
      for (i = 3; i >= 0; i--) fb.push_back(dest_w[8*i +: 8]);
      for (i = 3; i >= 0; i--) fb.push_back(src_w[8*i +: 8]);
      fb.push_back(hi_c);
      fb.push_back(lo_c);
      for (i = 0; i < n_pay; i++) fb.push_back(8'($urandom()));
      cut = (!big && $urandom_range(9) == 0) ? $urandom_range(1, fb.size() - 1) : fb.size();
      for (i = 0; i < cut; i++) begin
         if (!big && i != 0 && eff > 1 && $urandom_range(4) == 0) begin
            for (k = $urandom_range(1, eff - 1); k > 0; k--) push_idle();
         end
         push_byte(fb[i]);
      end
      if (cut != fb.size() && $urandom_range(1) == 0) begin
         for (k = 0; k < eff; k++) push_idle();
      end
      if ($urandom_range(6) == 0) begin
         for (k = $urandom_range(1, 3); k > 0; k--) push_idle();
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------

   task automatic report_error(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
      if (got !== exp_val)
         report_error($sformatf("%s got %0h, expected %0h", name, got, exp_val));
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: feeds beats from beats_q. A beat is held while stalled; valid stays high
   // across back-to-back beats and only drops when a gap is drawn or nothing is left.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            rx_predict(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (beats_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= beats_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random, or a long hold-off on request so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor: every accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            report_error($sformatf("result beat with nothing expected: %h", rsp_data));
         end else begin
            want = expected_q.pop_front();
            check_field("kind", rsp_data.kind, want.kind);
            check_field("payload_byte", rsp_data.payload_byte, want.payload_byte);
            check_field("last", rsp_data.last, want.last);
            check_field("match_class", rsp_data.match_class, want.match_class);
            check_field("alias_hit", rsp_data.alias_hit, want.alias_hit);
            check_field("source_address", rsp_data.source_address, want.source_address);
         end
      end
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------------------------------

   // Register write; the shadow follows at the handshake.
   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ALIAS_COUNT: alias_count  = val[ALIAS_CNT_W-1:0];
         CSR_ALIAS_A:     alias_reg[0] = val;
         CSR_ALIAS_B:     alias_reg[1] = val;
         CSR_ALIAS_C:     alias_reg[2] = val;
         CSR_ALIAS_D:     alias_reg[3] = val;
         CSR_IDLE_LIMIT:  idle_limit   = val[IDLE_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Close any open frame with a run of idle ticks longer than the largest limit, then
   // wait until every beat is in, every result is out and the pipeline has emptied.
   task automatic finish_phase();
      int k;
      for (k = 0; k <= 15; k++) push_idle();
      while (beats_q.size() != 0 || req_valid) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [ADDR_W-1:0] twin;
      logic [ADDR_W-1:0] other;
      int mark;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase 0: reset settings, directed beats. Sender idles 35%, receiver 80%.
      send_gap_pct = 35;
      stall_pct    = 80;
      push_idle();                        // idle with no frame open: no result
      push_addr(BROADCAST_ADDR);          // broadcast, source of extreme bytes,
      push_addr(32'hFF00_FF00);           // "AQ" = 16 bits = two payload bytes
      push_byte("A");
      push_byte("Q");
      push_byte(8'h00);
      push_byte(8'hFF);
      push_addr($urandom());              // length digits outside the alphabet,
      push_addr($urandom());              // so the frame ends empty
      push_byte("*");
      push_byte("~");
      finish_phase();

      // Phase 1: every register written. Alias count above the slot count, first alias
      // equal to broadcast, two equal aliases (first wins), zero idle limit.
      twin  = $urandom();
      other = $urandom();
      csr_write(CSR_ALIAS_COUNT, 7);
      csr_write(CSR_ALIAS_A, BROADCAST_ADDR);
      csr_write(CSR_ALIAS_B, twin);
      csr_write(CSR_ALIAS_C, twin);
      csr_write(CSR_ALIAS_D, other);
      csr_write(CSR_IDLE_LIMIT, 0);
      push_addr(twin);                    // header cut after one source char; the first
      push_byte(8'($urandom()));          // idle tick times out with a partial source
      push_idle();
      byte_count = 0;
      while (byte_count < 30) gen_frame(1'b0);
      finish_phase();

      // Phase 2: the other way round on idling, largest idle limit, writes to the
      // spare indexes that must be ignored.
      send_gap_pct = 80;
      stall_pct    = 35;
      csr_write(CSR_ALIAS_COUNT, ALIAS_SLOTS);
      csr_write(CSR_ALIAS_A, $urandom());
      csr_write(CSR_ALIAS_B, $urandom());
      csr_write(CSR_ALIAS_C, $urandom());
      csr_write(CSR_ALIAS_D, '1);
      csr_write(CSR_IDLE_LIMIT, 15);
      csr_write(CSR_SPARE_0, $urandom());
      csr_write(CSR_SPARE_1, $urandom());
      byte_count = 0;
      while (byte_count < 30) gen_frame(1'b0);
      finish_phase();

      // Phase 3: no idling, one alias in use, a mid-range limit, a longest-length frame,
      // and a long receiver hold-off while the sender keeps offering beats.
      send_gap_pct = 0;
      stall_pct    = 0;
      csr_write(CSR_ALIAS_COUNT, 1);
      csr_write(CSR_ALIAS_A, '0);
      csr_write(CSR_IDLE_LIMIT, $urandom_range(2, 14));
      byte_count = 0;
      while (byte_count < 10) gen_frame(1'b0);
      gen_frame(1'b1);
      mark = results_seen + 40;
      while (results_seen < mark) @(posedge clock);
      hold_req++;
      finish_phase();

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
